// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types, constants and calendar functions
// Operation codes, item and result structs, month table and the closed-form
// day counting used by the calendar arithmetic datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

  typedef enum logic [1:0] {
    OP_NEXT_DAY     = 2'd0,
    OP_PREV_DAY     = 2'd1,
    OP_DAY_OF_YEAR  = 2'd2,
    OP_DAYS_BETWEEN = 2'd3
  } cda_op_t;

  localparam logic [13:0] YEAR_LIMIT    = 14'd9999;
  localparam logic [21:0] DAY_COUNT_MAX = 22'd4194303;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [3:0] MONTH_TOP = 4'd15;

  typedef struct packed {
    cda_op_t     op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } cda_item_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] day_count;
    logic        out_of_range;
  } cda_result_t;

  // Days before month m in a common year; months 13 and 14 count 28 days.
  function automatic logic [8:0] before_month(logic [3:0] m);
    logic [8:0] days;
    case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      4'd13:   days = 9'd365;
      4'd14:   days = 9'd393;
      4'd15:   days = 9'd421;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic is_leap(logic [13:0] y);
    return (y[1:0] == 2'd0);
  endfunction

  function automatic logic [8:0] day_of_year(logic [4:0] d, logic [3:0] m, logic [13:0] y);
    logic [8:0] leap_adj;
    leap_adj = (m >= MONTH_MAR && is_leap(y)) ? 9'd1 : 9'd0;
    if (m == 4'd0) begin
      return 9'd0;
    end
    return before_month(m) + {4'd0, d} + leap_adj;
  endfunction

  // Days from the start of year 0 to the start of year y.
  function automatic logic [22:0] days_before_year(logic [13:0] y);
    logic [22:0] y_ext;
    logic [14:0] y_up;
    y_ext = {9'd0, y};
    y_up  = {1'b0, y} + 15'd3;
    return (y_ext * 23'd365) + {10'd0, y_up[14:2]};
  endfunction

endpackage

// ===== rtl/cda_core.sv =====
// ----------------------------------------------------------------------------
// cda_core: calendar arithmetic datapath
// Single-pass logic that steps a date or counts days for one transaction.
// ----------------------------------------------------------------------------
module cda_core
  import cda_pkg::*;
(
  input  cda_item_t   item,
  output cda_result_t res
);

  logic        short_month;
  logic        prev_is_31;
  logic        prev_is_30;
  logic [22:0] abs_a;
  logic [22:0] abs_b;
  logic [22:0] span;

  assign short_month = (item.month == MONTH_APR) || (item.month == MONTH_JUN) ||
                       (item.month == MONTH_SEP) || (item.month == MONTH_NOV);
  assign prev_is_31  = (item.month == MONTH_FEB) || (item.month == MONTH_APR) ||
                       (item.month == MONTH_JUN) || (item.month == MONTH_AUG) ||
                       (item.month == MONTH_SEP) || (item.month == MONTH_NOV);
  assign prev_is_30  = (item.month == MONTH_MAY) || (item.month == MONTH_JUL) ||
                       (item.month == MONTH_OCT) || (item.month == MONTH_DEC);

  assign abs_a = days_before_year(item.year) +
                 {14'd0, day_of_year(item.day, item.month, item.year)};
  assign abs_b = days_before_year(item.other_year) +
                 {14'd0, day_of_year(item.other_day, item.other_month, item.other_year)};
  assign span  = (abs_a > abs_b) ? (abs_a - abs_b) : (abs_b - abs_a);

  always_comb begin
    res.day          = item.day;
    res.month        = item.month;
    res.year         = item.year;
    res.day_count    = 22'd0;
    res.out_of_range = 1'b0;
    case (item.op)
      OP_NEXT_DAY: begin
        if (item.day == 5'd31 && item.month == MONTH_DEC) begin
          if (item.year >= YEAR_LIMIT) begin
            res.out_of_range = 1'b1;
          end else begin
            res.day   = 5'd1;
            res.month = MONTH_JAN;
            res.year  = item.year + 14'd1;
          end
        end else if (item.day == 5'd31) begin
          if (item.month == MONTH_TOP) begin
            res.out_of_range = 1'b1;
          end else begin
            res.day   = 5'd1;
            res.month = item.month + 4'd1;
          end
        end else if ((item.day == 5'd30 && short_month) ||
                     (item.day == 5'd29 && item.month == MONTH_FEB && is_leap(item.year)) ||
                     (item.day == 5'd28 && item.month == MONTH_FEB)) begin
          res.day   = 5'd1;
          res.month = item.month + 4'd1;
        end else begin
          res.day = item.day + 5'd1;
        end
      end
      OP_PREV_DAY: begin
        if (item.day == 5'd1 && item.month == MONTH_JAN) begin
          if (item.year == 14'd0) begin
            res.out_of_range = 1'b1;
          end else begin
            res.day   = 5'd31;
            res.month = MONTH_DEC;
            res.year  = item.year - 14'd1;
          end
        end else if (item.day == 5'd1 && prev_is_31) begin
          res.day   = 5'd31;
          res.month = item.month - 4'd1;
        end else if (item.day == 5'd1 && prev_is_30) begin
          res.day   = 5'd30;
          res.month = item.month - 4'd1;
        end else if (item.day == 5'd1 && item.month == MONTH_MAR) begin
          res.day   = is_leap(item.year) ? 5'd29 : 5'd28;
          res.month = MONTH_FEB;
        end else if (item.day == 5'd0) begin
          res.out_of_range = 1'b1;
        end else begin
          res.day = item.day - 5'd1;
        end
      end
      OP_DAY_OF_YEAR: begin
        res.day_count = {13'd0, day_of_year(item.day, item.month, item.year)};
      end
      OP_DAYS_BETWEEN: begin
        res.day_count = span[22] ? DAY_COUNT_MAX : span[21:0];
      end
      default: begin
        res.day_count = 22'd0;
      end
    endcase
  end

endmodule

// ===== rtl/calendar_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic: next day, previous day, day of year, days between
// Path: an accepted transaction is held in the input register, then in the
//   output register, which drives the out_ ports; out_ready can stall both.
// Throughput: one transaction per cycle while out_ready does not stall; the
//   input register feeds the single-pass datapath, whose result lands in the output register.
// Reset (rst_n low, synchronous) empties both registers; no result is shown.
// No internal state survives a transaction: every result depends only on its
//   own input fields.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic
  import cda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  input  logic [4:0]  in_other_day,
  input  logic [3:0]  in_other_month,
  input  logic [13:0] in_other_year,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_result_day,
  output logic [3:0]  out_result_month,
  output logic [13:0] out_result_year,
  output logic [21:0] out_day_count,
  output logic        out_out_of_range
);

  // Input register stage
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  cda_item_t   s1_item_r;

  // Output register stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  cda_result_t out_res_r;

  cda_result_t core_res;
  logic        out_adv;
  logic        s1_adv;

  // Advance the output register when it is empty or its transaction is taken;
  // the input register may then hand its item over and accept a new one.
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;

  assign s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the incoming transaction; hold it while the output stage stalls.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.op          <= cda_op_t'(in_operation);
      s1_item_r.day         <= in_day;
      s1_item_r.month       <= in_month;
      s1_item_r.year        <= in_year;
      s1_item_r.other_day   <= in_other_day;
      s1_item_r.other_month <= in_other_month;
      s1_item_r.other_year  <= in_other_year;
    end
  end

  cda_core u_core (
    .item (s1_item_r),
    .res  (core_res)
  );

  // Load the datapath result when the output register advances.
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_day   = out_res_r.day;
  assign out_result_month = out_res_r.month;
  assign out_result_year  = out_res_r.year;
  assign out_day_count    = out_res_r.day_count;
  assign out_out_of_range = out_res_r.out_of_range;

  // An accepted transaction always lands in the input register.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  // A stalled input register keeps its transaction.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost a stalled transaction");

  // A full input register moves into the output register when it advances.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("transaction dropped between stages");

  // Stepping that leaves the range never reports a count.
  a_oor_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.out_of_range) |-> (out_res_r.day_count == 22'd0))
    else $error("out_of_range result carries a day count");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule
